### hdl/frrd_pkg.sv
`default_nettype none

package frrd_pkg;

   localparam int DEFAULT_SAMPLE_BITS = 32;
   localparam int RESIDUAL_WIDTH      = 32;
   localparam int BLOCK_SIZE_WIDTH    = 16;
   localparam int PRED_ORDER_WIDTH    = 6;
   localparam int CSR_DATA_WIDTH      = 16;

   localparam logic [BLOCK_SIZE_WIDTH-1:0] BLOCK_SIZE_RESET = 16'd4096;
   localparam logic [PRED_ORDER_WIDTH-1:0] PRED_ORDER_RESET = 6'd0;

   // Escape codes for the narrow (4-bit) and wide (5-bit) Rice parameter.
   localparam logic [4:0] ESCAPE_NARROW = 5'h0F;
   localparam logic [4:0] ESCAPE_WIDE   = 5'h1F;

   localparam logic [5:0] METHOD_BITS     = 6'd2;
   localparam logic [5:0] ORDER_BITS      = 6'd4;
   localparam logic [5:0] PARAM_BITS_NARR = 6'd4;
   localparam logic [5:0] PARAM_BITS_WIDE = 6'd5;
   localparam logic [5:0] ESCW_BITS       = 6'd5;

   // Register indexes on the configuration port.
   typedef enum logic {
      CSR_BLOCK_SIZE = 1'b0,
      CSR_PRED_ORDER = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_METHOD,
      PH_ORDER,
      PH_PARAM,
      PH_ESCW,
      PH_UNARY,
      PH_REM,
      PH_RAW
   } phase_type;

   typedef struct packed {
      logic [BLOCK_SIZE_WIDTH-1:0] block_size;
      logic [PRED_ORDER_WIDTH-1:0] predictor_order;
   } cfg_type;

   typedef struct packed {
      logic                             valid;
      logic signed [RESIDUAL_WIDTH-1:0] residual;
      logic                             last_sample;
      logic                             bad_method;
   } result_type;

endpackage

`default_nettype wire

### hdl/flac_rice_residual_decoder_unit.sv
// A residual appears on the result channel in the cycle after the bit that completes it.
// Throughput: one stream bit per cycle while req_stall is low.
// The input stalls only while a residual waits in the result register under a result stall.
// Reset is synchronous and active high: the decoder restarts at the coding method,
// block_size returns to 4096, predictor_order to 0, and the result register empties.
`default_nettype none

module flac_rice_residual_decoder_unit #(
   parameter int SAMPLE_BITS = frrd_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_stream_bit,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [frrd_pkg::RESIDUAL_WIDTH-1:0] rsp_residual,
   output logic                                   rsp_last_sample,
   output logic                                   rsp_bad_method,
   input  logic                                   csr_write_enable,
   input  logic                                   csr_index,
   input  logic [frrd_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import frrd_pkg::*;

   cfg_type    cfg_ff;
   result_type result;
   logic       step;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [RESIDUAL_WIDTH-1:0] rsp_residual_ff;
   logic                             rsp_last_ff;
   logic                             rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_size      <= BLOCK_SIZE_RESET;
         cfg_ff.predictor_order <= PRED_ORDER_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE: cfg_ff.block_size <= csr_write_data;
            CSR_PRED_ORDER: cfg_ff.predictor_order <= csr_write_data[PRED_ORDER_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Hold off input only while a residual sits in the result register and cannot drain.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step      = req_valid && !req_stall;

   frrd_core #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .stream_bit (req_stream_bit),
      .cfg        (cfg_ff),
      .result     (result)
   );

   assign rsp_valid_in = result.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_residual_ff <= result.residual;
         rsp_last_ff     <= result.last_sample;
         rsp_bad_ff      <= result.bad_method;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_residual    = rsp_residual_ff;
   assign rsp_last_sample = rsp_last_ff;
   assign rsp_bad_method  = rsp_bad_ff;

endmodule

`default_nettype wire

### hdl/frrd_core.sv
`default_nettype none

module frrd_core #(
   parameter int SAMPLE_BITS = frrd_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 stream_bit,
   input  frrd_pkg::cfg_type    cfg,
   output frrd_pkg::result_type result
);
   import frrd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [5:0]  bits_left_ff, bits_left_in;
   logic        wide_ff, wide_in;
   logic [3:0]  order_ff, order_in;
   logic [15:0] parts_left_ff, parts_left_in;
   logic [15:0] samples_left_ff, samples_left_in;
   logic [4:0]  param_ff, param_in;
   logic        escaped_ff, escaped_in;
   logic [4:0]  escw_ff, escw_in;
   logic [31:0] quot_ff, quot_in;
   logic [31:0] acc_ff, acc_in;

   // Folds a value to SAMPLE_BITS signed bits and sign-extends it to 32.
   function automatic logic [31:0] wrap_sample(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) begin
         r[i] = (i < SAMPLE_BITS) ? v[i] : v[SAMPLE_BITS-1];
      end
      return r;
   endfunction

   function automatic logic [31:0] rice_value(input logic [31:0] q, input logic [4:0] k,
                                              input logic [31:0] r);
      logic [31:0] u;
      logic [31:0] s;
      u = (q << k) | r;
      s = {1'b0, u[31:1]} ^ {32{u[0]}};
      return wrap_sample(s);
   endfunction

   function automatic logic [31:0] raw_value(input logic [31:0] a, input logic [4:0] w);
      logic [31:0] sign;
      sign = 32'd1 << (w - 5'd1);
      return wrap_sample((a ^ sign) - sign);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_METHOD;
         bits_left_ff    <= METHOD_BITS;
         wide_ff         <= 1'b0;
         order_ff        <= '0;
         parts_left_ff   <= '0;
         samples_left_ff <= '0;
         param_ff        <= '0;
         escaped_ff      <= 1'b0;
         escw_ff         <= '0;
         quot_ff         <= '0;
         acc_ff          <= '0;
      end else begin
         phase_ff        <= phase_in;
         bits_left_ff    <= bits_left_in;
         wide_ff         <= wide_in;
         order_ff        <= order_in;
         parts_left_ff   <= parts_left_in;
         samples_left_ff <= samples_left_in;
         param_ff        <= param_in;
         escaped_ff      <= escaped_in;
         escw_ff         <= escw_in;
         quot_ff         <= quot_in;
         acc_ff          <= acc_in;
      end
   end

   always_comb begin
      logic [31:0] shifted;
      logic [5:0]  bits_dec;
      logic [15:0] share;
      logic [15:0] pred;
      logic [15:0] psize;
      logic [15:0] samples_dec;
      logic [15:0] parts_dec;
      logic        emit;
      logic        do_finish;
      logic        do_sample;
      logic [31:0] value;

      phase_in        = phase_ff;
      bits_left_in    = bits_left_ff;
      wide_in         = wide_ff;
      order_in        = order_ff;
      parts_left_in   = parts_left_ff;
      samples_left_in = samples_left_ff;
      param_in        = param_ff;
      escaped_in      = escaped_ff;
      escw_in         = escw_ff;
      quot_in         = quot_ff;
      acc_in          = acc_ff;

      shifted     = {acc_ff[30:0], stream_bit};
      bits_dec    = bits_left_ff - 6'd1;
      share       = cfg.block_size >> order_ff;
      pred        = {10'd0, cfg.predictor_order};
      samples_dec = samples_left_ff - 16'd1;
      parts_dec   = parts_left_ff - 16'd1;
      emit        = 1'b0;
      do_finish   = 1'b0;
      do_sample   = 1'b0;
      value       = '0;

      if (order_ff == 4'd0) begin
         psize = (cfg.block_size > pred) ? cfg.block_size - pred : 16'd0;
      end else if (parts_left_ff == (16'd1 << order_ff)) begin
         psize = (share > pred) ? share - pred : 16'd0;
      end else begin
         psize = share;
      end

      result.valid       = 1'b0;
      result.residual    = '0;
      result.last_sample = 1'b0;
      result.bad_method  = 1'b0;

      if (step) begin
         unique case (phase_ff)
            PH_METHOD: begin
               acc_in       = {30'd0, shifted[1:0]};
               bits_left_in = bits_dec;
               if (bits_dec == 6'd0) begin
                  if (shifted[1]) begin
                     // Reserved method: report it and restart the section.
                     result.valid      = 1'b1;
                     result.bad_method = 1'b1;
                     bits_left_in      = METHOD_BITS;
                     acc_in            = '0;
                  end else begin
                     wide_in      = shifted[0];
                     phase_in     = PH_ORDER;
                     bits_left_in = ORDER_BITS;
                     acc_in       = '0;
                  end
               end
            end
            PH_ORDER: begin
               acc_in       = {28'd0, shifted[3:0]};
               bits_left_in = bits_dec;
               if (bits_dec == 6'd0) begin
                  order_in      = shifted[3:0];
                  parts_left_in = 16'd1 << shifted[3:0];
                  phase_in      = PH_PARAM;
                  bits_left_in  = wide_ff ? PARAM_BITS_WIDE : PARAM_BITS_NARR;
                  acc_in        = '0;
               end
            end
            PH_PARAM: begin
               acc_in       = {27'd0, shifted[4:0]};
               bits_left_in = bits_dec;
               if (bits_dec == 6'd0) begin
                  param_in        = shifted[4:0];
                  escaped_in      = wide_ff ? (shifted[4:0] == ESCAPE_WIDE)
                                            : (shifted[4:0] == ESCAPE_NARROW);
                  samples_left_in = psize;
                  if (escaped_in) begin
                     phase_in     = PH_ESCW;
                     bits_left_in = ESCW_BITS;
                     acc_in       = '0;
                  end else if (psize == 16'd0) begin
                     do_finish = 1'b1;
                  end else begin
                     do_sample = 1'b1;
                  end
               end
            end
            PH_ESCW: begin
               acc_in       = {27'd0, shifted[4:0]};
               bits_left_in = bits_dec;
               if (bits_dec == 6'd0) begin
                  escw_in = shifted[4:0];
                  if (samples_left_ff == 16'd0) begin
                     do_finish = 1'b1;
                  end else begin
                     do_sample = 1'b1;
                  end
               end
            end
            PH_UNARY: begin
               if (!stream_bit) begin
                  if (quot_ff != 32'hFFFF_FFFF) begin
                     quot_in = quot_ff + 32'd1;
                  end
               end else if (param_ff == 5'd0) begin
                  emit  = 1'b1;
                  value = rice_value(quot_ff, 5'd0, 32'd0);
               end else begin
                  phase_in     = PH_REM;
                  bits_left_in = {1'b0, param_ff};
                  acc_in       = '0;
               end
            end
            PH_REM: begin
               acc_in       = shifted;
               bits_left_in = bits_dec;
               if (bits_dec == 6'd0) begin
                  emit  = 1'b1;
                  value = rice_value(quot_ff, param_ff, shifted);
               end
            end
            PH_RAW: begin
               if (escw_ff == 5'd0) begin
                  // A zero-width sample consumes one stream bit and ignores it.
                  emit  = 1'b1;
                  value = '0;
               end else begin
                  acc_in       = shifted;
                  bits_left_in = bits_dec;
                  if (bits_dec == 6'd0) begin
                     emit  = 1'b1;
                     value = raw_value(shifted, escw_ff);
                  end
               end
            end
            default: begin
               phase_in     = PH_METHOD;
               bits_left_in = METHOD_BITS;
               acc_in       = '0;
            end
         endcase

         if (emit) begin
            result.valid    = 1'b1;
            result.residual = value;
            samples_left_in = samples_dec;
            if (samples_dec == 16'd0) begin
               do_finish = 1'b1;
            end else begin
               do_sample = 1'b1;
            end
         end

         if (do_finish) begin
            parts_left_in = parts_dec;
            if (parts_dec == 16'd0) begin
               result.last_sample = emit;
               phase_in           = PH_METHOD;
               bits_left_in       = METHOD_BITS;
               acc_in             = '0;
            end else begin
               phase_in     = PH_PARAM;
               bits_left_in = wide_ff ? PARAM_BITS_WIDE : PARAM_BITS_NARR;
               acc_in       = '0;
            end
         end

         if (do_sample) begin
            acc_in  = '0;
            quot_in = '0;
            if (escaped_in) begin
               phase_in     = PH_RAW;
               bits_left_in = {1'b0, escw_in};
            end else begin
               phase_in = PH_UNARY;
            end
         end
      end
   end

endmodule

`default_nettype wire

### hdl/frrd_checker.sv
`default_nettype none

module frrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_residual,
   input logic        rsp_last_sample,
   input logic        rsp_bad_method
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_residual)
         && $stable(rsp_last_sample) && $stable(rsp_bad_method))
      else $error("stalled result changed");

   // The input side must back off while the result register is blocked.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input not stalled behind a blocked result");

   // A reserved-method report carries no sample.
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_method |-> rsp_residual == 32'd0 && !rsp_last_sample)
      else $error("bad_method result carries data");

   // A fresh result follows an input transfer in the cycle before.
   a_fresh_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(reset) && !($past(rsp_valid) && $past(rsp_stall))
         |-> $past(req_valid) && !$past(req_stall))
      else $error("result without an input transfer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result register not empty after reset");

endmodule

bind flac_rice_residual_decoder_unit frrd_checker u_frrd_checker (.*);

`default_nettype wire

### tb/flac_rice_residual_decoder_unit_tb.sv
module flac_rice_residual_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import frrd_pkg::*;

   localparam int SAMPLE_BITS  = DEFAULT_SAMPLE_BITS;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 4;
   localparam int REPORT_LIMIT = 10;

   logic                             clock;
   logic                             reset            = 1'b1;
   logic                             req_valid        = 1'b0;
   logic                             req_stall;
   logic                             req_stream_bit   = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall        = 1'b0;
   logic signed [RESIDUAL_WIDTH-1:0] rsp_residual;
   logic                             rsp_last_sample;
   logic                             rsp_bad_method;
   logic                             csr_write_enable = 1'b0;
   logic                             csr_index        = 1'b0;
   logic [CSR_DATA_WIDTH-1:0]        csr_write_data   = '0;

   flac_rice_residual_decoder_unit #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_bit   (req_stream_bit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_residual     (rsp_residual),
      .rsp_last_sample  (rsp_last_sample),
      .rsp_bad_method   (rsp_bad_method),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register copies, kept in step with every write on the configuration port.
   logic [BLOCK_SIZE_WIDTH-1:0] cfg_block_size = BLOCK_SIZE_RESET;
   logic [PRED_ORDER_WIDTH-1:0] cfg_pred_order = PRED_ORDER_RESET;

   // Decoder state as it stands after reset.
   phase_type   dec_phase        = PH_METHOD;
   logic [5:0]  dec_bits_left    = METHOD_BITS;
   logic        dec_wide         = 1'b0;
   logic [3:0]  dec_order        = '0;
   logic [15:0] dec_parts_left   = '0;
   logic [15:0] dec_samples_left = '0;
   logic [4:0]  dec_param        = '0;
   logic        dec_escaped      = 1'b0;
   logic [4:0]  dec_escape_width = '0;
   logic [31:0] dec_quotient     = '0;
   logic [31:0] dec_acc          = '0;

   logic       pending_bits[$];
   result_type expected_residuals[$];
   result_type expected_now;
   int         bits_queued       = 0;
   int         error_count       = 0;
   int         cycle_count       = 0;
   int         sender_idle_pct   = 33;
   int         receiver_idle_pct = 65;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] part_samples(input logic [3:0] order, input logic first);
      logic [15:0] share;
      share = cfg_block_size >> order;
      if (order == 0)
         return (cfg_block_size > cfg_pred_order) ? cfg_block_size - cfg_pred_order : 16'd0;
      if (first)
         return (share > cfg_pred_order) ? share - cfg_pred_order : 16'd0;
      return share;
   endfunction

   function automatic logic [31:0] wrap_to_sample(input logic [63:0] v);
      logic [63:0] m, s, w;
      m = (64'd1 << SAMPLE_BITS) - 64'd1;
      s = 64'd1 << (SAMPLE_BITS - 1);
      w = ((v & m) ^ s) - s;
      return w[31:0];
   endfunction

   function automatic void push_residual(input logic [31:0] value, input logic last,
                                         input logic bad);
      result_type r;
      r.valid       = 1'b1;
      r.residual    = value;
      r.last_sample = last;
      r.bad_method  = bad;
      expected_residuals.push_back(r);
   endfunction

   function automatic void begin_section();
      dec_phase     = PH_METHOD;
      dec_bits_left = METHOD_BITS;
      dec_acc       = '0;
   endfunction

   function automatic void begin_param();
      dec_phase     = PH_PARAM;
      dec_bits_left = dec_wide ? PARAM_BITS_WIDE : PARAM_BITS_NARR;
      dec_acc       = '0;
   endfunction

   // Returns 1 when the closed partition was the last one of the section.
   function automatic logic close_partition();
      dec_parts_left = dec_parts_left - 16'd1;
      if (dec_parts_left == 0) begin
         begin_section();
         return 1'b1;
      end
      begin_param();
      return 1'b0;
   endfunction

   function automatic void begin_sample();
      dec_acc      = '0;
      dec_quotient = '0;
      if (dec_escaped) begin
         dec_phase     = PH_RAW;
         dec_bits_left = {1'b0, dec_escape_width};
      end else begin
         dec_phase = PH_UNARY;
      end
   endfunction

   function automatic void emit_residual(input logic [31:0] value);
      logic last;
      last = 1'b0;
      dec_samples_left = dec_samples_left - 16'd1;
      if (dec_samples_left == 0)
         last = close_partition();
      else
         begin_sample();
      push_residual(value, last, 1'b0);
   endfunction

   function automatic void decode_bit(input logic b);
      logic [63:0] wide_v, sgn;
      logic [31:0] mask, rem, folded, unfolded;
      logic        rice_done, ignored;
      rice_done = 1'b0;
      case (dec_phase)
         PH_METHOD: begin
            dec_acc       = ((dec_acc << 1) | b) & 32'h3;
            dec_bits_left = dec_bits_left - 6'd1;
            if (dec_bits_left == 0) begin
               if (dec_acc >= 2) begin
                  begin_section();
                  push_residual('0, 1'b0, 1'b1);
               end else begin
                  dec_wide      = dec_acc[0];
                  dec_phase     = PH_ORDER;
                  dec_bits_left = ORDER_BITS;
                  dec_acc       = '0;
               end
            end
         end
         PH_ORDER: begin
            dec_acc       = ((dec_acc << 1) | b) & 32'hF;
            dec_bits_left = dec_bits_left - 6'd1;
            if (dec_bits_left == 0) begin
               dec_order      = dec_acc[3:0];
               dec_parts_left = 16'd1 << dec_order;
               begin_param();
            end
         end
         PH_PARAM: begin
            dec_acc       = ((dec_acc << 1) | b) & 32'h1F;
            dec_bits_left = dec_bits_left - 6'd1;
            if (dec_bits_left == 0) begin
               dec_param   = dec_acc[4:0];
               dec_escaped = dec_wide ? (dec_param == ESCAPE_WIDE) : (dec_param == ESCAPE_NARROW);
               dec_samples_left = part_samples(dec_order, dec_parts_left == (16'd1 << dec_order));
               if (dec_escaped) begin
                  dec_phase     = PH_ESCW;
                  dec_bits_left = ESCW_BITS;
                  dec_acc       = '0;
               end else if (dec_samples_left == 0) begin
                  ignored = close_partition();
               end else begin
                  begin_sample();
               end
            end
         end
         PH_ESCW: begin
            dec_acc       = ((dec_acc << 1) | b) & 32'h1F;
            dec_bits_left = dec_bits_left - 6'd1;
            if (dec_bits_left == 0) begin
               dec_escape_width = dec_acc[4:0];
               if (dec_samples_left == 0)
                  ignored = close_partition();
               else
                  begin_sample();
            end
         end
         PH_UNARY: begin
            if (b == 1'b0) begin
               if (dec_quotient != 32'hFFFF_FFFF)
                  dec_quotient = dec_quotient + 32'd1;
            end else if (dec_param == 0) begin
               rice_done = 1'b1;
            end else begin
               dec_phase     = PH_REM;
               dec_bits_left = {1'b0, dec_param};
               dec_acc       = '0;
            end
         end
         PH_REM: begin
            dec_acc       = (dec_acc << 1) | b;
            dec_bits_left = dec_bits_left - 6'd1;
            if (dec_bits_left == 0)
               rice_done = 1'b1;
         end
         PH_RAW: begin
            // A zero-width escaped sample still takes one bit, which is dropped.
            if (dec_escape_width == 0) begin
               emit_residual('0);
            end else begin
               dec_acc       = (dec_acc << 1) | b;
               dec_bits_left = dec_bits_left - 6'd1;
               if (dec_bits_left == 0) begin
                  sgn    = 64'd1 << (dec_escape_width - 1);
                  wide_v = ({32'd0, dec_acc} ^ sgn) - sgn;
                  emit_residual(wrap_to_sample(wide_v));
               end
            end
         end
         default: begin
            begin_section();
         end
      endcase
      if (rice_done) begin
         mask     = (dec_param == 0) ? 32'd0 : ((32'd1 << dec_param) - 32'd1);
         rem      = dec_acc & mask;
         wide_v   = ({32'd0, dec_quotient} << dec_param) | {32'd0, rem};
         folded   = wide_v[31:0];
         unfolded = (folded >> 1) ^ (32'd0 - {31'd0, folded[0]});
         emit_residual(wrap_to_sample({{32{unfolded[31]}}, unfolded}));
      end
   endfunction

   // Stream construction, most significant bit first.
   function automatic void push_field(input logic [31:0] value, input int width);
      for (int i = width - 1; i >= 0; i--)
         pending_bits.push_back(value[i]);
      bits_queued += width;
   endfunction

   function automatic void push_rice(input int q, input logic [31:0] r, input int k);
      repeat (q) push_field(32'd0, 1);
      push_field(32'd1, 1);
      push_field(r, k);
   endfunction

   // A well-formed section for the current registers. In cheap mode every sample
   // costs one bit, which keeps the very large sections short.
   function automatic void gen_section(input logic [1:0] method, input logic [3:0] order,
                                       input logic cheap);
      int         n, pw, k, kmax, ew, q;
      logic [4:0] code;
      push_field(32'(method), 2);
      if (method >= 2)
         return;
      push_field(32'(order), 4);
      pw   = method[0] ? 5 : 4;
      kmax = method[0] ? 30 : 14;
      code = method[0] ? ESCAPE_WIDE : ESCAPE_NARROW;
      for (int p = 0; p < (1 << order); p++) begin
         n = int'(part_samples(order, p == 0));
         if ($urandom_range(4) == 0) begin
            push_field(32'(code), pw);
            ew = cheap ? 0 : ($urandom_range(1) ? $urandom_range(31) : $urandom_range(8));
            push_field(ew, 5);
            repeat (n) push_field($urandom, (ew == 0) ? 1 : ew);
         end else begin
            k = cheap ? 0 : (($urandom_range(3) != 0) ? $urandom_range(4) : $urandom_range(kmax));
            push_field(k, pw);
            repeat (n) begin
               q = cheap ? 0 : (($urandom_range(7) != 0) ? $urandom_range(3) : $urandom_range(40));
               push_rice(q, $urandom, k);
            end
         end
      end
   endfunction

   // Waits until every bit has been taken and every residual has come back.
   task automatic settle();
      do @(negedge clock);
      while (pending_bits.size() != 0 || req_valid || expected_residuals.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_BLOCK_SIZE)
         cfg_block_size = data;
      else
         cfg_pred_order = data[PRED_ORDER_WIDTH-1:0];
   endtask

   task automatic reconfigure(input logic [15:0] bs, input logic [5:0] po);
      settle();
      write_csr(CSR_BLOCK_SIZE, bs);
      write_csr(CSR_PRED_ORDER, {10'd0, po});
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            decode_bit(req_stream_bit);
         if (!req_valid || !req_stall) begin
            if (pending_bits.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid      <= 1'b1;
               req_stream_bit <= pending_bits.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_residuals.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("unexpected residual %0d last %0b bad %0b", rsp_residual,
                           rsp_last_sample, rsp_bad_method);
            end else begin
               expected_now = expected_residuals.pop_front();
               if (rsp_residual !== expected_now.residual ||
                   rsp_last_sample !== expected_now.last_sample ||
                   rsp_bad_method !== expected_now.bad_method) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("mismatch: expected %0d last %0b bad %0b, got %0d last %0b bad %0b",
                              expected_now.residual, expected_now.last_sample,
                              expected_now.bad_method, rsp_residual, rsp_last_sample,
                              rsp_bad_method);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int mark;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Both reserved coding methods under the reset register values.
      push_field(2, 2);
      push_field(3, 2);

      reconfigure(16'd3, 6'd0);
      // Zero parameter: quotient alone gives 0, -1, 1.
      push_field(0, 2); push_field(0, 4); push_field(0, 4);
      push_rice(0, 0, 0); push_rice(1, 0, 0); push_rice(2, 0, 0);
      // Widest parameter: both ends of the residual range, then a quotient that wraps.
      push_field(1, 2); push_field(0, 4); push_field(30, 5);
      push_rice(3, 32'h3FFF_FFFF, 30); push_rice(3, 32'h3FFF_FFFE, 30); push_rice(5, 1, 30);
      // Narrow escape with the widest raw samples.
      push_field(0, 2); push_field(0, 4); push_field(32'(ESCAPE_NARROW), 4); push_field(31, 5);
      push_field(32'h7FFF_FFFF, 31); push_field(32'h4000_0000, 31); push_field(0, 31);
      // Wide escape with zero width: the three sample bits are dropped.
      push_field(1, 2); push_field(0, 4); push_field(32'(ESCAPE_WIDE), 5); push_field(0, 5);
      push_field(32'b101, 3);
      // 0xF is an ordinary parameter when the parameter is five bits wide.
      push_field(1, 2); push_field(0, 4); push_field(15, 5);
      push_rice(0, 32'h7FFF, 15); push_rice(1, 0, 15); push_rice(0, 32'h2AAA, 15);
      // One-bit escaped samples hold only a sign.
      push_field(0, 2); push_field(0, 4); push_field(32'(ESCAPE_NARROW), 4); push_field(1, 5);
      push_field(32'b101, 3);

      // The first partition loses all its samples to the warm-up.
      reconfigure(16'd4, 6'd2);
      push_field(0, 2); push_field(1, 4); push_field(32'(ESCAPE_NARROW), 4); push_field(5, 5);
      push_field(1, 4); push_rice(0, 0, 1); push_rice(0, 1, 1);
      gen_section(2'd1, 4'd1, 1'b0);

      // More warm-up than samples: the section ends without a last sample.
      reconfigure(16'd1, 6'd32);
      push_field(0, 2); push_field(0, 4); push_field(2, 4);
      gen_section(2'd1, 4'd0, 1'b0);

      for (int mode = 0; mode < 3; mode++) begin
         sender_idle_pct   = (mode == 0) ? 33 : (mode == 1) ? 65 : 0;
         receiver_idle_pct = (mode == 0) ? 65 : (mode == 1) ? 33 : 0;
         repeat (2) begin
            reconfigure(($urandom_range(3) == 0) ? 16'($urandom_range(17, 40))
                                                  : 16'($urandom_range(1, 16)),
                        ($urandom_range(4) == 0) ? 6'($urandom_range(9, 32))
                                                  : 6'($urandom_range(0, 4)));
            mark = bits_queued;
            while (bits_queued - mark < 60) begin
               if ($urandom_range(9) == 0)
                  gen_section(2'($urandom_range(2, 3)), 4'd0, 1'b0);
               else
                  gen_section(2'($urandom_range(1)),
                              4'(($urandom_range(7) == 0) ? $urandom_range(5)
                                                          : $urandom_range(2)), 1'b0);
            end
         end
      end

      // Deepest warm-up over a partitioned block: the first partition is empty and
      // every other sample costs one bit.
      reconfigure(16'd64, 6'd32);
      gen_section(2'd0, 4'd2, 1'b1);

      // A tail of unstructured bits.
      reconfigure(16'd8, 6'd0);
      repeat (40) push_field($urandom, 1);

      settle();
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
